@@ rtl/lfd_pkg.sv @@
// Shared types, constants and arithmetic helpers of the LED flicker dimmer.
// No dependencies; every other file of the block refers to this package.
package lfd_pkg;

    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam logic [15:0] FRAMES_PER_DRAIN_RST = 16'd120;
    localparam logic [7:0]  BATTERY_START_RST = 8'd255;
    localparam logic [7:0]  FULL_SCALE        = 8'd255;
    localparam logic [7:0]  LONG_PLATEAU      = 8'd191;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_FRAMES_PER_DRAIN = 2'd0;
    localparam logic [1:0] REG_BATTERY_START    = 2'd1;

    // One classified frame: base level and the envelope factors to apply
    typedef struct packed {
        logic [7:0] level;
        logic       short_on;
        logic [7:0] short_env;
        logic       long_on;
        logic [7:0] long_env;
    } job_t;

    // V-shaped short dip over 64 positions
    function automatic logic [7:0] short_env(input logic [5:0] p);
        logic [6:0] d;
        d = 7'd64 - {1'b0, p};
        if (!p[5])
            return FULL_SCALE - {p, 2'b00};
        else
            return FULL_SCALE - {d[5:0], 2'b00};
    endfunction

    // Long dip: ramp down, plateau, ramp up over 256 positions
    function automatic logic [7:0] long_env(input logic [7:0] p);
        logic [8:0] d;
        d = 9'd256 - {1'b0, p};
        if (p < 8'd32)
            return FULL_SCALE - {2'b00, p[4:0], 1'b0};
        else if (p < 8'd224)
            return LONG_PLATEAU;
        else
            return FULL_SCALE - {1'b0, d[5:0], 1'b0};
    endfunction

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

@@ rtl/lfd_fifo.sv @@
// Short job queue between the frame front end and the scaling back end.
// Depends on lfd_pkg for the job type.
module lfd_fifo #(
    parameter int unsigned DEPTH = lfd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfd_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output lfd_pkg::job_t head,
    output logic          empty
);
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    lfd_pkg::job_t     mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/lfd_front.sv @@
// Front end: accepts frame words, advances battery and dip state, classifies.
// Depends on lfd_pkg for the job type, envelopes and register indexes.
module lfd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [5:0]    short_roll,
    input  logic [7:0]    long_roll,
    output logic          push,
    output lfd_pkg::job_t push_data,
    input  logic          q_full
);
    logic [15:0] fpd_reg;
    logic [7:0]  battery_reg;
    logic [15:0] phase_reg;
    logic        short_on_reg, long_on_reg;
    logic [5:0]  short_pos_reg;
    logic [7:0]  long_pos_reg;

    logic        short_on, long_on, drain;
    logic [5:0]  short_pos_next;
    logic [7:0]  long_pos_next;
    logic [15:0] limit;
    logic [8:0]  mid;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        // An idle dip starts on a zero roll and already scales this frame
        short_on       = short_on_reg || (short_roll == '0);
        long_on        = long_on_reg || (long_roll == '0);
        short_pos_next = short_pos_reg + 1'b1;
        long_pos_next  = long_pos_reg + 1'b1;
        mid            = ({1'b0, battery_reg} + 9'd255) >> 1;
        limit          = (fpd_reg == '0) ? 16'd1 : fpd_reg;
        drain          = ({1'b0, phase_reg} + 17'd1) >= {1'b0, limit};

        push_data.level     = mid[7:0];
        push_data.short_on  = short_on;
        push_data.short_env = lfd_pkg::short_env(short_pos_reg);
        push_data.long_on   = long_on;
        push_data.long_env  = lfd_pkg::long_env(long_pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpd_reg       <= lfd_pkg::FRAMES_PER_DRAIN_RST;
            battery_reg   <= lfd_pkg::BATTERY_START_RST;
            phase_reg     <= '0;
            short_on_reg  <= 1'b0;
            short_pos_reg <= '0;
            long_on_reg   <= 1'b0;
            long_pos_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lfd_pkg::REG_FRAMES_PER_DRAIN)
                fpd_reg <= cfg_data;
            else if (cfg_index == lfd_pkg::REG_BATTERY_START)
                battery_reg <= cfg_data[7:0];
        end
        else if (push)
        begin
            if (short_on)
            begin
                short_pos_reg <= short_pos_next;
                short_on_reg  <= (short_pos_next != '0);
            end
            if (long_on)
            begin
                long_pos_reg <= long_pos_next;
                long_on_reg  <= (long_pos_next != '0);
            end
            if (drain)
            begin
                phase_reg <= '0;
                if (battery_reg != '0)
                    battery_reg <= battery_reg - 1'b1;
            end
            else
                phase_reg <= phase_reg + 1'b1;
        end
    end

endmodule

@@ rtl/lfd_back.sv @@
// Back end: applies the dip envelopes to the base level, one multiply or
// one divide-by-255 step per cycle, and holds the result word for the sink.
// Depends on lfd_pkg for the job type and div255.
module lfd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lfd_pkg::job_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    brightness
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_DIV_S,
        ST_MUL_L,
        ST_DIV_L,
        ST_FIN
    } state_t;

    state_t        state_reg;
    lfd_pkg::job_t job_reg;
    logic [7:0]    lvl_reg;
    logic [15:0]   prod_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    assign pop        = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid  = out_valid_reg;
    assign brightness = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            job_reg       <= '0;
            lvl_reg       <= '0;
            prod_reg      <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Drop the output word once taken, unless a new one is loaded now
            if (out_valid_reg && out_ready && (state_reg != ST_FIN))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg <= head;
                        lvl_reg <= head.level;
                        if (head.short_on)
                            state_reg <= ST_MUL_S;
                        else if (head.long_on)
                            state_reg <= ST_MUL_L;
                        else
                            state_reg <= ST_FIN;
                    end
                end
                ST_MUL_S:
                begin
                    prod_reg  <= {8'd0, lvl_reg} * {8'd0, job_reg.short_env};
                    state_reg <= ST_DIV_S;
                end
                ST_DIV_S:
                begin
                    lvl_reg   <= lfd_pkg::div255(prod_reg);
                    state_reg <= job_reg.long_on ? ST_MUL_L : ST_FIN;
                end
                ST_MUL_L:
                begin
                    prod_reg  <= {8'd0, lvl_reg} * {8'd0, job_reg.long_env};
                    state_reg <= ST_DIV_L;
                end
                ST_DIV_L:
                begin
                    lvl_reg   <= lfd_pkg::div255(prod_reg);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // Wait for the output register to free up
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg  <= lvl_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_s_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_S) |-> $past(state_reg == ST_MUL_S))
        else $error("short divide without multiply");
    a_div_l_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_L) |-> $past(state_reg == ST_MUL_L))
        else $error("long divide without multiply");
    a_scale_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (lvl_reg <= job_reg.level))
        else $error("scaled level above base level");

endmodule

@@ rtl/led_flicker_dimmer_top.sv @@
// Top level of the LED flicker dimmer: front end, job queue, scaling back end.
// Depends on lfd_pkg, lfd_front, lfd_fifo and lfd_back.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  s_      | in  | tvalid / tready  | tdata[5:0] short_roll, [13:6] long_roll
//  m_      | out | tvalid / tready  | tdata[7:0] brightness
//  cfg_    | in  | we (no wait)     | index 0 frames_per_drain, 1 battery_start
//
// One input word becomes one output word. The front end takes a word
// whenever the queue has room; the back end then works on one job at a
// time: it takes the job, runs a multiply and a divide-by-255 step for each
// active dip, short dip first, and then loads the output register. Sustained
// rate is bounded by the back end, which waits to load while the sink stalls.
// Reset (rst_n low, asynchronous) loads the register defaults, fills the
// battery, parks both dips and empties the queue and output register.
// A stalled sink holds the output word; the input side keeps taking words
// until the queue is full.
module led_flicker_dimmer_top #(
    parameter int unsigned QUEUE_DEPTH = lfd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // frame words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] short_roll, [13:6] long_roll, [15:14] zero
    // brightness words out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] brightness
);
    lfd_pkg::job_t push_data, head;
    logic          push, pop, q_full, q_empty;

    lfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .short_roll (s_tdata[5:0]),
        .long_roll  (s_tdata[13:6]),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    // Hold classified frames while the back end is busy
    lfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    lfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .brightness (m_tdata)
    );

endmodule
